// ===== rtl/core/ssr_pkg.sv =====
// shared types and register map for the substring replace unit
package ssr_pkg;

  // configuration register width and address layout
  localparam int LEN_W      = 5;
  localparam int PAT_W      = 128;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  // register index, taken from paddr bits [5:3]
  typedef enum logic [2:0] {
    REG_SEARCH_LEN  = 3'd0,
    REG_REPLACE_LEN = 3'd1,
    REG_SEARCH_LO   = 3'd2,
    REG_SEARCH_HI   = 3'd3,
    REG_REPLACE_LO  = 3'd4,
    REG_REPLACE_HI  = 3'd5
  } reg_idx_t;

  // configuration as seen by the front end
  typedef struct packed {
    logic [LEN_W-1:0] search_length;
    logic [LEN_W-1:0] replace_length;
    logic [PAT_W-1:0] search_bytes;
    logic [PAT_W-1:0] replace_bytes;
  } cfg_t;

endpackage

// ===== rtl/core/ssr_front.sv =====
// front end: pending window, pattern compare and burst command build
module ssr_front #(
  parameter int PAT_MAX  = 16,
  parameter int REPL_MAX = 16,
  parameter int BURST    = 16,
  parameter int CW       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ssr_pkg::cfg_t       cfg,
  input  logic                slen_clear,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_ready,
  output logic                push,
  output logic [BURST*8-1:0]  push_data,
  output logic [CW-1:0]       push_cnt,
  output logic                push_last
);

  localparam int WIN_D = (PAT_MAX > 1) ? PAT_MAX - 1 : 1;
  localparam int NW    = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int SLW   = $clog2(PAT_MAX + 1);

  logic [7:0]         win_r [WIN_D];
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [SLW-1:0]     slen, slen_m1;
  logic [CW-1:0]      rlen;
  logic [7:0]         cand [PAT_MAX+1];
  logic [PAT_MAX-1:0] ok;
  logic [BURST*8-1:0] cand_flat;
  logic               full, hit, in_fire;

  // ascii case folding, A-Z to a-z
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  assign in_tready = q_ready;
  assign in_fire   = in_tvalid & q_ready;

  // clamp the configured lengths
  always_comb begin
    if (cfg.search_length == '0) begin
      slen = SLW'(1);
    end else if (cfg.search_length > ssr_pkg::LEN_W'(PAT_MAX)) begin
      slen = SLW'(PAT_MAX);
    end else begin
      slen = SLW'(cfg.search_length);
    end
    if (cfg.replace_length > ssr_pkg::LEN_W'(REPL_MAX)) begin
      rlen = CW'(REPL_MAX);
    end else begin
      rlen = CW'(cfg.replace_length);
    end
  end

  assign slen_m1 = slen - SLW'(1);
  assign full    = (SLW'(cnt_r) == slen_m1);

  // candidate string: pending bytes followed by the new byte
  for (genvar k = 0; k <= PAT_MAX; k++) begin : g_cand
    if (k < PAT_MAX - 1) begin : g_win
      assign cand[k] = (NW'(k) < cnt_r) ? win_r[k] : in_tdata;
    end else begin : g_new
      assign cand[k] = in_tdata;
    end
  end

  // parallel compare, first byte exact, the rest case-folded
  for (genvar k = 0; k < PAT_MAX; k++) begin : g_cmp
    if (k == 0) begin : g_first
      assign ok[k] = (cand[0] == cfg.search_bytes[7:0]);
    end else begin : g_rest
      assign ok[k] = (SLW'(k) >= slen) ||
                     (fold(cand[k]) == fold(cfg.search_bytes[8*k +: 8]));
    end
  end

  assign hit = full & (&ok);

  // flatten candidate bytes for the burst payload
  for (genvar k = 0; k < BURST; k++) begin : g_flat
    if (k < PAT_MAX) begin : g_byte
      assign cand_flat[8*k +: 8] = cand[k];
    end else begin : g_pad
      assign cand_flat[8*k +: 8] = 8'h00;
    end
  end

  // burst command for the back end
  always_comb begin
    push_data = hit ? cfg.replace_bytes[BURST*8-1:0] : cand_flat;
    if (hit) begin
      push_cnt = rlen;
    end else if (in_tlast) begin
      push_cnt = CW'(cnt_r) + CW'(1);
    end else if (full) begin
      push_cnt = CW'(1);
    end else begin
      push_cnt = '0;
    end
    push_last = in_tlast;
    push      = in_fire & ((push_cnt != '0) | in_tlast);
  end

  // pending count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (slen_clear) begin
      cnt_nxt = '0;
    end else if (in_fire) begin
      if (in_tlast || hit) begin
        cnt_nxt = '0;
      end else if (!full) begin
        cnt_nxt = cnt_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes: shift out the oldest when full, else append
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < WIN_D; k++) begin
        win_r[k] <= full ? cand[k+1] : cand[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SLW'(cnt_r) <= slen_m1)
    else $error("pending count exceeds search length minus one");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |-> push)
    else $error("last byte accepted without a burst command");
`endif

endmodule

// ===== rtl/core/ssr_queue.sv =====
// small fifo of burst commands between front and back end
module ssr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   count_r;
  logic             do_push, do_pop;

  assign ready    = (count_r != CNW'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push & ready;
  assign do_pop   = pop & valid;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNW'(DEPTH))
    else $error("queue fill level out of range");
`endif

endmodule

// ===== rtl/core/ssr_back.sv =====
// back end: plays each burst command out one byte per transaction
module ssr_back #(
  parameter int BURST = 16,
  parameter int CW    = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [BURST*8-1:0] cmd_data,
  input  logic [CW-1:0]      cmd_cnt,
  input  logic               cmd_last,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);

  logic               busy_r;
  logic [BURST*8-1:0] data_r;
  logic [CW-1:0]      rem_r;
  logic               flag_r, last_r;
  logic               out_fire, final_beat;

  assign out_fire   = busy_r & out_tready;
  assign final_beat = (rem_r <= CW'(1));
  assign cmd_pop    = cmd_valid & (!busy_r | (out_fire & final_beat));

  // output view of the current command
  assign out_tvalid = busy_r;
  assign out_tdata  = flag_r ? data_r[7:0] : 8'h00;
  assign out_tuser  = flag_r;
  assign out_tlast  = last_r & final_beat;

  // command state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      flag_r <= 1'b0;
      last_r <= 1'b0;
    end else if (cmd_pop) begin
      busy_r <= 1'b1;
      rem_r  <= cmd_cnt;
      flag_r <= (cmd_cnt != '0);
      last_r <= cmd_last;
    end else if (out_fire) begin
      if (final_beat) begin
        busy_r <= 1'b0;
      end else begin
        rem_r <= rem_r - CW'(1);
      end
    end
  end

  // byte shifter
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      data_r <= cmd_data;
    end else if (out_fire) begin
      data_r <= data_r >> 8;
    end
  end

`ifndef SYNTHESIS
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("bare end marker without last");

  a_data_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && flag_r) |-> (rem_r != '0))
    else $error("data beat with no bytes remaining");
`endif

endmodule

// ===== rtl/core/stream_substring_replace_unit.sv =====
// top level of the streaming substring replace unit with its register file
//
// Takes one source byte per transaction (tlast on the final byte) and replaces every leftmost,
// non-overlapping match of the search pattern with the replacement string; the first pattern
// byte must match exactly, the rest match without regard to ascii case. The front end accepts
// one byte per cycle whenever the command queue (QUEUE_DEPTH entries) has room; the back end
// emits one output byte per cycle while out_tready is high; a match yields replace_length
// bytes, an unmatched byte one, and the end of a string flushes up to search_length window
// bytes. tuser on the output is 0 only for a bare end marker, sent when the final input byte
// leaves nothing to emit. Registers sit at byte address 8*index; writing search_length drops
// any pending bytes. Write configuration only while the stream is idle; it is not enforced.
module stream_substring_replace_unit #(
  parameter int PAT_MAX     = 16,
  parameter int REPL_MAX    = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // in_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // out_byte
  output logic                           out_tuser,  // out_valid
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ssr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ssr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int BURST = (PAT_MAX > REPL_MAX) ? PAT_MAX : REPL_MAX;
  localparam int CW    = $clog2(BURST + 1);
  localparam int QW    = BURST * 8 + CW + 1;

  logic [ssr_pkg::LEN_W-1:0]      search_length_r, replace_length_r;
  logic [ssr_pkg::CFG_DATA_W-1:0] search_lo_r, search_hi_r, replace_lo_r, replace_hi_r;
  logic                           cfg_wr, slen_clear;
  logic [2:0]                     cfg_idx;
  ssr_pkg::cfg_t                  cfg;

  logic               push, q_ready, q_valid, q_pop;
  logic [BURST*8-1:0] push_data, pop_data;
  logic [CW-1:0]      push_cnt, pop_cnt;
  logic               push_last, pop_last;

  // apb write decode, zero wait states
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign slen_clear = cfg_wr & (cfg_idx == ssr_pkg::REG_SEARCH_LEN);

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_length_r  <= ssr_pkg::LEN_W'(1);
      replace_length_r <= '0;
      search_lo_r      <= '0;
      search_hi_r      <= '0;
      replace_lo_r     <= '0;
      replace_hi_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ssr_pkg::REG_SEARCH_LEN:  search_length_r  <= cfg_pwdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REPLACE_LEN: replace_length_r <= cfg_pwdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_SEARCH_LO:   search_lo_r      <= cfg_pwdata;
        ssr_pkg::REG_SEARCH_HI:   search_hi_r      <= cfg_pwdata;
        ssr_pkg::REG_REPLACE_LO:  replace_lo_r     <= cfg_pwdata;
        ssr_pkg::REG_REPLACE_HI:  replace_hi_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      ssr_pkg::REG_SEARCH_LEN:  cfg_prdata = ssr_pkg::CFG_DATA_W'(search_length_r);
      ssr_pkg::REG_REPLACE_LEN: cfg_prdata = ssr_pkg::CFG_DATA_W'(replace_length_r);
      ssr_pkg::REG_SEARCH_LO:   cfg_prdata = search_lo_r;
      ssr_pkg::REG_SEARCH_HI:   cfg_prdata = search_hi_r;
      ssr_pkg::REG_REPLACE_LO:  cfg_prdata = replace_lo_r;
      ssr_pkg::REG_REPLACE_HI:  cfg_prdata = replace_hi_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  // configuration bundle for the front end
  always_comb begin
    cfg.search_length  = search_length_r;
    cfg.replace_length = replace_length_r;
    cfg.search_bytes   = {search_hi_r, search_lo_r};
    cfg.replace_bytes  = {replace_hi_r, replace_lo_r};
  end

  ssr_front #(
    .PAT_MAX  (PAT_MAX),
    .REPL_MAX (REPL_MAX),
    .BURST    (BURST),
    .CW       (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .slen_clear (slen_clear),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_ready    (q_ready),
    .push       (push),
    .push_data  (push_data),
    .push_cnt   (push_cnt),
    .push_last  (push_last)
  );

  ssr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_last, push_cnt, push_data}),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_data  ({pop_last, pop_cnt, pop_data}),
    .valid     (q_valid)
  );

  ssr_back #(
    .BURST (BURST),
    .CW    (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cmd_data   (pop_data),
    .cmd_cnt    (pop_cnt),
    .cmd_last   (pop_last),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
